// ===== rtl/owpid_pkg.sv =====
// ----------------------------------------------------------------------------
// Omni wheel PID drive package
// Shared widths, register indexes, configuration and lane control types.
// ----------------------------------------------------------------------------
`default_nettype none

package owpid_pkg;

  localparam int NUM_WHEELS     = 3;
  localparam int SPD_W          = 16;
  localparam int GAIN_W         = 16;
  localparam int LIM_W          = 15;
  localparam int PWM_W          = 15;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int ERR_W  = SPD_W + 1;
  localparam int PREV_W = SPD_W + 2;
  localparam int DER_W  = PREV_W + 1;
  localparam int ACC_W  = GAIN_W + DER_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 6 * SPD_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = ((2 * NUM_WHEELS * PWM_W + 7) / 8) * 8;

  typedef logic signed [SPD_W-1:0] spd_t;
  typedef logic [PWM_W-1:0]        pwm_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4,
    REG_PWM_MAX        = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [LIM_W-1:0]  integral_limit;
    logic [LIM_W-1:0]  output_limit;
    logic [LIM_W-1:0]  pwm_max;
  } cfg_t;

  typedef struct packed {
    logic err_en;
    logic mul_en;
    logic sum_en;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/owpid_kin.sv =====
// ----------------------------------------------------------------------------
// Omni wheel kinematics
// Turns body velocity and turn rate into three saturated wheel targets.
// ----------------------------------------------------------------------------
`default_nettype none

module owpid_kin import owpid_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic mul_en,
  input  logic tgt_en,
  input  spd_t vel_y,
  input  spd_t vel_x,
  input  spd_t turn_rate,
  input  logic stop,
  input  logic recompute_targets,
  output spd_t targets [NUM_WHEELS]
);

  localparam int KY_W  = 2 * SPD_W + 1;
  localparam int COM_W = 2 * SPD_W + 1;
  localparam int SUM_W = KY_W + 1;
  localparam logic signed [SPD_W:0] KIN_COS30 = 17'sd28377;
  localparam logic signed [SUM_W-1:0] SPD_MAX = SUM_W'(2 ** (SPD_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SPD_MIN = -SUM_W'(2 ** (SPD_W - 1));

  logic signed [KY_W-1:0]  ky;
  logic signed [COM_W-1:0] common;
  logic signed [SUM_W-1:0] sum_left;
  logic signed [SUM_W-1:0] sum_right;
  logic signed [SUM_W-1:0] rear_diff;

  function automatic spd_t sat_spd(input logic signed [SUM_W-1:0] x);
    if (x > SPD_MAX) begin
      return SPD_MAX[SPD_W-1:0];
    end else if (x < SPD_MIN) begin
      return SPD_MIN[SPD_W-1:0];
    end
    return x[SPD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (mul_en) begin
      ky     <= KIN_COS30 * vel_y;
      common <= (COM_W'(vel_x) <<< 14) + (COM_W'(turn_rate) <<< 15) + COM_W'(16384);
    end
  end

  always_comb begin
    sum_left  = (SUM_W'(ky) + SUM_W'(common)) >>> 15;
    sum_right = (SUM_W'(common) - SUM_W'(ky)) >>> 15;
    rear_diff = SUM_W'(turn_rate) - SUM_W'(vel_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        targets[w] <= '0;
      end
    end else if (tgt_en && recompute_targets) begin
      if (stop) begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
          targets[w] <= '0;
        end
      end else begin
        targets[0] <= sat_spd(sum_left);
        targets[1] <= sat_spd(sum_right);
        targets[2] <= sat_spd(rear_diff);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/owpid_lane.sv =====
// ----------------------------------------------------------------------------
// Omni wheel PID lane
// One wheel's error, clamped integral, derivative, gain products and PWM split.
// ----------------------------------------------------------------------------
`default_nettype none

module owpid_lane import owpid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  cfg_t       cfg,
  input  spd_t       target,
  input  spd_t       meas,
  output pwm_t       fwd,
  output pwm_t       rev
);

  localparam int ISUM_W = ERR_W + 1;

  spd_t                     integ;
  logic signed [PREV_W-1:0] prev_err;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DER_W-1:0]  deriv;
  logic signed [DER_W-1:0]  deriv_r;
  logic signed [ISUM_W-1:0] isum;
  logic signed [ISUM_W-1:0] ilim;
  logic signed [ISUM_W-1:0] iclamp;
  logic signed [ACC_W-1:0]  p_prod;
  logic signed [ACC_W-1:0]  i_prod;
  logic signed [ACC_W-1:0]  d_prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         mag;
  logic [ACC_W-1:0]         scaled;
  pwm_t                     out_clamp;
  pwm_t                     duty;
  logic                     neg;

  always_comb begin
    err   = ERR_W'(target) - ERR_W'(meas);
    isum  = ISUM_W'(integ) + ISUM_W'(err);
    ilim  = $signed({{(ISUM_W - LIM_W){1'b0}}, cfg.integral_limit});
    deriv = DER_W'(err) - DER_W'(prev_err);
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      prev_err <= '0;
    end else if (ctrl.err_en) begin
      integ    <= iclamp[SPD_W-1:0];
      prev_err <= PREV_W'(err);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.err_en) begin
      err_r   <= err;
      deriv_r <= deriv;
    end
    if (ctrl.mul_en) begin
      p_prod <= $signed({1'b0, cfg.prop_gain}) * err_r;
      i_prod <= $signed({1'b0, cfg.integ_gain}) * integ;
      d_prod <= $signed({1'b0, cfg.deriv_gain}) * deriv_r;
    end
  end

  always_comb begin
    acc    = p_prod + i_prod + d_prod;
    neg    = acc[ACC_W-1];
    mag    = neg ? $unsigned(-acc) : $unsigned(acc);
    scaled = mag >> GAIN_FRAC_BITS;
    if (scaled > ACC_W'(cfg.output_limit)) begin
      out_clamp = cfg.output_limit;
    end else begin
      out_clamp = scaled[PWM_W-1:0];
    end
    if (out_clamp > cfg.pwm_max) begin
      duty = cfg.pwm_max;
    end else begin
      duty = out_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      fwd <= neg ? '0 : duty;
      rev <= neg ? duty : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/owpid_merge.sv =====
// ----------------------------------------------------------------------------
// Omni wheel PID result merge
// Packs the three lanes' duty pairs into one result held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module owpid_merge import owpid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  pwm_t                  fwd [NUM_WHEELS],
  input  pwm_t                  rev [NUM_WHEELS],
  output logic                  free,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [OUT_DATA_W-1:0] packed_data;

  always_comb begin
    packed_data = '0;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      packed_data[2 * w * PWM_W +: PWM_W]       = fwd[w];
      packed_data[(2 * w + 1) * PWM_W +: PWM_W] = rev[w];
    end
    free = !m_axis_tvalid || m_axis_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= packed_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/omni_wheel_speed_pid_drive_unit.sv =====
// ----------------------------------------------------------------------------
// Omni wheel speed PID drive unit
// Three-wheel omni kinematics feeding three parallel wheel PID lanes.
// ----------------------------------------------------------------------------
// Each request carries one control tick and yields one result with forward
// and reverse duty for the left front, right front and rear wheels. After
// acceptance a tick passes through these steps in order: the constant multiply
// of the kinematics, the targets, error and integral, the three gain multiplies
// in each lane, the sum and clamps, and the load of the output register.
// The load waits while an earlier result is still held in the output register.
// The sequencer handles one tick at a time, so the next request is taken once
// the previous result has been loaded, even while that result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_wheel_speed_pid_drive_unit import owpid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vel_y, vel_x, turn_rate, meas_left, meas_right, meas_rear
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // stop, recompute_targets
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // left_fwd, left_rev, right_fwd, right_rev, rear_fwd, rear_rev, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_KIN  = 7'b0000010,
    ST_TGT  = 7'b0000100,
    ST_ERR  = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_SUM  = 7'b0100000,
    ST_PUSH = 7'b1000000
  } state_t;

  state_t     state;
  state_t     state_next;
  cfg_t       cfg;
  lane_ctrl_t lane_ctrl;
  spd_t       vel_y;
  spd_t       vel_x;
  spd_t       turn_rate;
  spd_t       meas [NUM_WHEELS];
  logic       stop;
  logic       recompute_targets;
  spd_t       targets [NUM_WHEELS];
  pwm_t       fwd [NUM_WHEELS];
  pwm_t       rev [NUM_WHEELS];
  logic       out_free;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= GAIN_W'(1280);
      cfg.integ_gain     <= '0;
      cfg.deriv_gain     <= GAIN_W'(26);
      cfg.integral_limit <= LIM_W'(3000);
      cfg.output_limit   <= LIM_W'(6000);
      cfg.pwm_max        <= LIM_W'(6000);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PROP_GAIN:      cfg.prop_gain      <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[LIM_W-1:0];
        REG_OUTPUT_LIMIT:   cfg.output_limit   <= cfg_data[LIM_W-1:0];
        REG_PWM_MAX:        cfg.pwm_max        <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      vel_y             <= s_axis_tdata[0 * SPD_W +: SPD_W];
      vel_x             <= s_axis_tdata[1 * SPD_W +: SPD_W];
      turn_rate         <= s_axis_tdata[2 * SPD_W +: SPD_W];
      meas[0]           <= s_axis_tdata[3 * SPD_W +: SPD_W];
      meas[1]           <= s_axis_tdata[4 * SPD_W +: SPD_W];
      meas[2]           <= s_axis_tdata[5 * SPD_W +: SPD_W];
      stop              <= s_axis_tuser[0];
      recompute_targets <= s_axis_tuser[1];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_KIN;
      ST_KIN:  state_next = ST_TGT;
      ST_TGT:  state_next = ST_ERR;
      ST_ERR:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_PUSH;
      ST_PUSH: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    lane_ctrl.err_en = (state == ST_ERR);
    lane_ctrl.mul_en = (state == ST_MUL);
    lane_ctrl.sum_en = (state == ST_SUM);
  end

  owpid_kin u_kin (
    .clk               (clk),
    .rst               (rst),
    .mul_en            (state == ST_KIN),
    .tgt_en            (state == ST_TGT),
    .vel_y             (vel_y),
    .vel_x             (vel_x),
    .turn_rate         (turn_rate),
    .stop              (stop),
    .recompute_targets (recompute_targets),
    .targets           (targets)
  );

  for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_lane
    owpid_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lane_ctrl),
      .cfg    (cfg),
      .target (targets[w]),
      .meas   (meas[w]),
      .fwd    (fwd[w]),
      .rev    (rev[w])
    );
  end

  owpid_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          ((state == ST_PUSH) && out_free),
    .fwd           (fwd),
    .rev           (rev),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/omni_wheel_speed_pid_drive_unit_test.sv =====
// ----------------------------------------------------------------------------
// Omni wheel speed PID drive unit testbench
// Sends control ticks through the input stream and checks every duty result
// against a cycle-free predictor of the kinematics and the three wheel PID
// loops, or the table value for typed rows. Several gain and limit settings
// are applied, including the extremes, with random gaps on both stream sides.
// ----------------------------------------------------------------------------

module omni_wheel_speed_pid_drive_unit_test import owpid_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam int    KIN_COS30     = 28377;
  localparam int    RAND_PHASES   = 9;
  localparam int    PHASE_TICKS   = 205;
  localparam int    SETTLE_CYCLES = 12;
  localparam int    DRAIN_LIMIT   = 5000;
  localparam spd_t  SPD_MAX       = 16'sh7FFF;
  localparam spd_t  SPD_MIN       = 16'sh8000;

  typedef struct packed {
    spd_t vy;
    spd_t vx;
    spd_t turn;
    spd_t ml;
    spd_t mr;
    spd_t mb;
    logic stop;
    logic recomp;
  } tick_t;

  // Highest field first, so the struct matches the low bits of the result bus bit for bit.
  typedef struct packed {
    pwm_t br;
    pwm_t bf;
    pwm_t rr;
    pwm_t rf;
    pwm_t lr;
    pwm_t lf;
  } duty_t;

  typedef struct packed {
    tick_t tick;
    logic  typed;
    duty_t want;
  } dir_row_t;

  localparam duty_t NO_DUTY = '0;
  localparam duty_t FWD_CAP = '{br: 0, bf: 6000, rr: 0, rf: 6000, lr: 0, lf: 6000};
  localparam duty_t REV_CAP = '{br: 6000, bf: 0, rr: 6000, rf: 0, lr: 6000, lf: 0};

  localparam int DIR_ROWS = 20;

  // Default settings after reset; the first rows start from the cleared state.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}, 1'b1, NO_DUTY},
    '{'{16'sd0, 16'sd0, 16'sd0, SPD_MIN, SPD_MIN, SPD_MIN, 1'b0, 1'b0}, 1'b1, FWD_CAP},
    '{'{16'sd0, 16'sd0, 16'sd0, SPD_MAX, SPD_MAX, SPD_MAX, 1'b0, 1'b0}, 1'b1, REV_CAP},
    '{'{16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{16'sd0, 16'sd1000, 16'sd0, 16'sd800, -16'sd500, -16'sd900, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{16'sd0, 16'sd0, 16'sd1000, 16'sd900, 16'sd950, 16'sd1000, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{16'sd500, -16'sd300, 16'sd200, 16'sd100, -16'sd100, 16'sd50, 1'b0, 1'b1},
      1'b0, NO_DUTY},
    '{'{16'sd900, 16'sd700, -16'sd400, 16'sd400, -16'sd200, 16'sd60, 1'b1, 1'b0},
      1'b0, NO_DUTY},
    '{'{16'sd500, -16'sd300, 16'sd200, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0, NO_DUTY},
    '{'{SPD_MAX, SPD_MAX, SPD_MAX, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{SPD_MIN, SPD_MIN, SPD_MIN, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{16'sd0, SPD_MAX, SPD_MIN, SPD_MIN, SPD_MAX, SPD_MAX, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{SPD_MIN, 16'sd0, 16'sd0, SPD_MAX, SPD_MIN, 16'sd0, 1'b0, 1'b1}, 1'b0, NO_DUTY},
    '{'{16'sd2000, -16'sd2000, 16'sd300, 16'sd1500, -16'sd2500, 16'sd300, 1'b0, 1'b1},
      1'b0, NO_DUTY},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0, NO_DUTY},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0, NO_DUTY}
  };

  string duty_names [6] = '{"left_fwd", "left_rev", "right_fwd", "right_rev",
                            "rear_fwd", "rear_rev"};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  cfg_t                    drv_cfg;
  spd_t                    wheel_tgt [NUM_WHEELS];
  logic signed [SPD_W-1:0] wheel_integ [NUM_WHEELS];
  logic signed [PREV_W-1:0] wheel_last_err [NUM_WHEELS];
  duty_t                   duty_due [$];
  int                      err_count = 0;
  int                      stall_left = 0;
  bit                      calm = 1'b0;

  omni_wheel_speed_pid_drive_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic spd_t clamp_speed(longint v);
    if (v > 32767) return SPD_MAX;
    if (v < -32768) return SPD_MIN;
    return v[SPD_W-1:0];
  endfunction

  function automatic duty_t predict_duty(tick_t t);
    longint ky, common, err, integ, acc, mag, ilim;
    spd_t   meas [NUM_WHEELS];
    duty_t  d;
    meas[0] = t.ml;
    meas[1] = t.mr;
    meas[2] = t.mb;
    d = '0;
    if (t.recomp) begin
      if (t.stop) begin
        for (int w = 0; w < NUM_WHEELS; w++) wheel_tgt[w] = '0;
      end else begin
        ky     = longint'(KIN_COS30) * longint'(t.vy);
        common = 16384 * longint'(t.vx) + 32768 * longint'(t.turn) + 16384;
        wheel_tgt[0] = clamp_speed((ky + common) >>> 15);
        wheel_tgt[1] = clamp_speed((common - ky) >>> 15);
        wheel_tgt[2] = clamp_speed(longint'(t.turn) - longint'(t.vx));
      end
    end
    ilim = longint'(drv_cfg.integral_limit);
    for (int w = 0; w < NUM_WHEELS; w++) begin
      err   = longint'(wheel_tgt[w]) - longint'(meas[w]);
      integ = longint'(wheel_integ[w]) + err;
      if (integ > ilim) integ = ilim;
      if (integ < -ilim) integ = -ilim;
      wheel_integ[w] = integ[SPD_W-1:0];
      acc = longint'(drv_cfg.prop_gain) * err
          + longint'(drv_cfg.integ_gain) * integ
          + longint'(drv_cfg.deriv_gain) * (err - longint'(wheel_last_err[w]));
      wheel_last_err[w] = err[PREV_W-1:0];
      mag = (acc < 0) ? -acc : acc;
      mag = mag >> GAIN_FRAC_BITS;
      if (mag > longint'(drv_cfg.output_limit)) mag = longint'(drv_cfg.output_limit);
      if (mag > longint'(drv_cfg.pwm_max)) mag = longint'(drv_cfg.pwm_max);
      if (acc < 0) begin
        d[(2 * w + 1) * PWM_W +: PWM_W] = mag[PWM_W-1:0];
      end else begin
        d[2 * w * PWM_W +: PWM_W] = mag[PWM_W-1:0];
      end
    end
    return d;
  endfunction

  function automatic spd_t rand_speed();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return clamp_speed(longint'($urandom_range(0, 4000)) - 2000);
      4, 5, 6:    return spd_t'($urandom);
      7:          return SPD_MIN;
      8:          return SPD_MAX;
      default:    return clamp_speed(longint'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  function automatic spd_t wheel_speed(spd_t aim);
    if ($urandom_range(0, 2) != 0) begin
      return clamp_speed(longint'(aim) + longint'($urandom_range(0, 600)) - 300);
    end
    return rand_speed();
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom_range(0, 1023));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:      drv_cfg.prop_gain = val;
      REG_INTEG_GAIN:     drv_cfg.integ_gain = val;
      REG_DERIV_GAIN:     drv_cfg.deriv_gain = val;
      REG_INTEGRAL_LIMIT: drv_cfg.integral_limit = val[LIM_W-1:0];
      REG_OUTPUT_LIMIT:   drv_cfg.output_limit = val[LIM_W-1:0];
      REG_PWM_MAX:        drv_cfg.pwm_max = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_tick(input tick_t t, input logic typed, input duty_t want);
    duty_t pred;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t.mb, t.mr, t.ml, t.turn, t.vx, t.vy};
    s_axis_tuser  <= {t.recomp, t.stop};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = predict_duty(t);
    duty_due.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && duty_due.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    duty_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = duty_t'(m_axis_tdata[6*PWM_W-1:0]);
        if (duty_due.size() == 0) begin
          note_error($sformatf("Unexpected result %h", got));
        end else begin
          want = duty_due.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (got[f*PWM_W +: PWM_W] !== want[f*PWM_W +: PWM_W]) begin
              note_error($sformatf("Mismatch on %s: expected %0d, got %0d", duty_names[f],
                                   want[f*PWM_W +: PWM_W], got[f*PWM_W +: PWM_W]));
            end
          end
        end
      end
      if (calm) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    tick_t                 t;
    logic [CFG_DATA_W-1:0] g_p, g_i, g_d, l_i, l_o, l_pwm;
    drv_cfg = '{prop_gain: 1280, integ_gain: 0, deriv_gain: 26,
                integral_limit: 3000, output_limit: 6000, pwm_max: 6000};
    for (int w = 0; w < NUM_WHEELS; w++) begin
      wheel_tgt[w] = '0;
      wheel_integ[w] = '0;
      wheel_last_err[w] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_tick(dir_tab[r].tick, dir_tab[r].typed, dir_tab[r].want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case (p)
        0: begin
          g_p = '0; g_i = '0; g_d = '0; l_i = '0; l_o = '0; l_pwm = '0;
        end
        1: begin
          g_p = '1; g_i = '1; g_d = '1; l_i = '1; l_o = '1; l_pwm = '1;
        end
        2: begin
          g_p = 16'd256; g_i = 16'd40; g_d = 16'd96;
          l_i = 16'd800; l_o = 16'd32767; l_pwm = 16'd9000;
        end
        default: begin
          g_p = pick_reg(); g_i = pick_reg(); g_d = pick_reg();
          l_i = pick_reg(); l_o = pick_reg(); l_pwm = pick_reg();
        end
      endcase
      cfg_write(IDX_SPARE_LO, CFG_DATA_W'($urandom));
      cfg_write(REG_PROP_GAIN, g_p);
      cfg_write(REG_INTEG_GAIN, g_i);
      cfg_write(REG_DERIV_GAIN, g_d);
      cfg_write(REG_INTEGRAL_LIMIT, l_i);
      cfg_write(REG_OUTPUT_LIMIT, l_o);
      cfg_write(REG_PWM_MAX, l_pwm);
      cfg_write(IDX_SPARE_HI, CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;
      if (p == RAND_PHASES - 1) calm = 1'b1;

      for (int i = 0; i < PHASE_TICKS; i++) begin
        t.vy     = rand_speed();
        t.vx     = rand_speed();
        t.turn   = rand_speed();
        t.ml     = wheel_speed(wheel_tgt[0]);
        t.mr     = wheel_speed(wheel_tgt[1]);
        t.mb     = wheel_speed(wheel_tgt[2]);
        t.recomp = ($urandom_range(0, 9) < 6);
        t.stop   = ($urandom_range(0, 6) == 0);
        send_tick(t, 1'b0, NO_DUTY);
      end
    end

    drain();
    if (duty_due.size() != 0) begin
      note_error($sformatf("%0d results never arrived", duty_due.size()));
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
